// ===== hdl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the sorted-cell min-priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

   // Number of cells, and the width of a counter that can hold it
   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;

   // Operation codes
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_PEEK    = 2'd1,
      OP_POP     = 2'd2,
      OP_PRELOAD = 2'd3
   } func_type;

   // Request word
   typedef struct packed {
      logic [1:0]              func;
      logic signed [VAL_W-1:0] value;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic signed [VAL_W-1:0] min_value;
      logic                    is_empty;
      logic                    overflow;
   } rsp_word_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                    insert;
      logic                    pop;
      logic signed [VAL_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted row: holds a value, compares it with the broadcast
// insert value and shifts toward or away from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell (
   input  wire logic                            clock,
   input  wire mpq_pkg::cell_cmd_type           cmd,
   input  wire logic                            occupied,
   input  wire logic                            left_lt,
   input  wire logic signed [mpq_pkg::VAL_W-1:0] left_value,
   input  wire logic signed [mpq_pkg::VAL_W-1:0] right_value,
   output logic signed [mpq_pkg::VAL_W-1:0]      value,
   output logic                                  lt
);
   import mpq_pkg::*;

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   // New value goes ahead of this slot when strictly smaller; empty slot acts as +inf
   assign lt = !occupied || (cmd.value < value_ff);

   // Insert: keep, take the new word, or take the left neighbor's word.
   // Pop: take the right neighbor's word.
   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (lt) begin
            value_in = left_lt ? left_value : cmd.value;
         end
      end else if (cmd.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== hdl/min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_core
// Bounded min-priority queue built as a row of sorted cells.
// ----------------------------------------------------------------------------
// Response: the strobe is registered, so the response word is strobed in the cycle after the request is taken.
// Throughput: one request word per cycle while busy is low; each operation is one parallel
// compare-and-shift step across the cell row.
// Reset: synchronous; the queue comes out empty, busy is high during reset.
// The receiver cannot stall; preload requests give no response.
`default_nettype none

module min_priority_queue_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire mpq_pkg::req_word_type req_word,
   output logic                       strobe,
   output mpq_pkg::rsp_word_type      rsp_word
);
   import mpq_pkg::*;

   logic             busy_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             strobe_ff, strobe_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             full;
   logic             is_ins;
   logic             ins_ok;
   logic             pop_ok;
   cell_cmd_type     cmd;

   logic signed [VAL_W-1:0] cell_val [CAPACITY];
   logic                    cell_lt  [CAPACITY];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign is_ins = (req_word.func == OP_INSERT) || (req_word.func == OP_PRELOAD);
   assign ins_ok = accept && is_ins && !full;
   assign pop_ok = accept && (req_word.func == OP_POP) && (count_ff != '0);

   // Broadcast command
   assign cmd.insert = ins_ok;
   assign cmd.pop    = pop_ok;
   assign cmd.value  = req_word.value;

   // Fill count and response control
   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
      strobe_in = accept && (req_word.func != OP_PRELOAD);
      ovf_in    = accept && (req_word.func == OP_INSERT) && full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Cell row, smallest value in cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    occ;
      logic                    l_lt;
      logic signed [VAL_W-1:0] l_val;
      logic signed [VAL_W-1:0] r_val;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign l_lt  = 1'b0;
         assign l_val = req_word.value;
      end else begin : g_mid
         assign l_lt  = cell_lt[i-1];
         assign l_val = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_val = cell_val[i];
      end else begin : g_inner
         assign r_val = cell_val[i+1];
      end

      mpq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occ),
         .left_lt     (l_lt),
         .left_value  (l_val),
         .right_value (r_val),
         .value       (cell_val[i]),
         .lt          (cell_lt[i])
      );
   end

   // Response word
   assign busy               = busy_ff;
   assign strobe             = strobe_ff;
   assign rsp_word.is_empty  = (count_ff == '0);
   assign rsp_word.min_value = (count_ff == '0) ? '0 : cell_val[0];
   assign rsp_word.overflow  = ovf_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_in |=> strobe)
      else $error("response strobe missing");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (strobe && rsp_word.overflow) |-> full && !rsp_word.is_empty)
      else $error("overflow flagged while not full");

   a_ins_min: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.func == OP_INSERT && !full)
      |=> (!rsp_word.is_empty && rsp_word.min_value <= $past(req_word.value)))
      else $error("minimum above inserted value");

endmodule

`default_nettype wire

// ===== tb/min_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_priority_queue_core_tb
// Self-checking bench for the sorted-cell min-priority queue. Request words
// come from a pending queue filled at time zero: a short directed opening,
// then fill, drain and mixed bursts with random values and random gaps. A
// predictor holds its own sorted copy of the queue, and every strobed
// response word is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------

module min_priority_queue_core_tb;

   import mpq_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int RESET_CYC   = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_ITEMS  = 400;

   // Operation mix of one random burst
   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX
   } burst_mode_type;

   // One request word waiting to be driven
   typedef struct {
      req_word_type word;
      int           gap;
      bit           drain;
   } pending_req_type;

   logic         clock;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         strobe;
   rsp_word_type rsp_word;

   pending_req_type          pending_q[$];
   rsp_word_type             min_report_q[$];
   logic signed [VAL_W-1:0]  sorted_vals[$];

   int gap_left;
   int quiet;
   int err_count;
   int cycle_count;
   int req_count;
   int rsp_count;
   int drop_count;
   int empty_count;
   int max_depth;

   min_priority_queue_core DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .strobe   (strobe),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: applies one accepted word to the sorted copy
   // ------------------------------------------------------------------------
   task automatic predict_min_report(input req_word_type w);
      rsp_word_type r;
      bit           dropped;
      int           pos;
      dropped = 1'b0;
      req_count++;
      case (func_type'(w.func))
         OP_INSERT, OP_PRELOAD: begin
            if (sorted_vals.size() >= CAPACITY) begin
               dropped = 1'b1;
               drop_count++;
            end else begin
               // new value goes behind equal ones
               pos = sorted_vals.size();
               while (pos > 0 && w.value < sorted_vals[pos-1])
                  pos--;
               sorted_vals.insert(pos, w.value);
            end
         end
         OP_POP: begin
            if (sorted_vals.size() != 0)
               void'(sorted_vals.pop_front());
         end
         default: ;
      endcase
      if (sorted_vals.size() > max_depth)
         max_depth = sorted_vals.size();
      // preload stays silent
      if (func_type'(w.func) != OP_PRELOAD) begin
         r.is_empty  = (sorted_vals.size() == 0);
         r.min_value = r.is_empty ? '0 : sorted_vals[0];
         r.overflow  = dropped;
         if (r.is_empty)
            empty_count++;
         min_report_q.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic signed [VAL_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end else if (sel <= 3) begin
         // narrow range, plenty of duplicates
         return $signed($urandom_range(0, 40)) - 20;
      end
      return $urandom;
   endfunction

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic func_type pick_func(input burst_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 45) return OP_INSERT;
            if (r < 80) return OP_PRELOAD;
            if (r < 90) return OP_PEEK;
            return OP_POP;
         end
         MODE_DRAIN: begin
            if (r < 65) return OP_POP;
            if (r < 80) return OP_PEEK;
            if (r < 90) return OP_INSERT;
            return OP_PRELOAD;
         end
         default: return func_type'(r % 4);
      endcase
   endfunction

   task automatic queue_req(input func_type f, input logic signed [VAL_W-1:0] v,
                            input int gap, input bit drain);
      pending_req_type p;
      p.word.func  = f;
      p.word.value = v;
      p.gap        = gap;
      p.drain      = drain;
      pending_q.push_back(p);
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents the front word, holds it until taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bit taken;
      taken = start && !busy;
      if (reset) begin
         start    <= 1'b0;
         req_word <= '0;
         gap_left = 0;
         quiet    = 0;
      end else begin
         if (taken) begin
            predict_min_report(pending_q[0].word);
            void'(pending_q.pop_front());
            quiet = 0;
            if (pending_q.size() != 0)
               gap_left = pending_q[0].gap;
         end else if (quiet < 100) begin
            quiet++;
         end
         if (start && !taken) begin
            // word still waiting, keep it on the port
         end else if (pending_q.size() == 0) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_q[0].drain && (min_report_q.size() != 0 || quiet < 2)) begin
            // hold off until every response is in
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_word <= pending_q[0].word;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each strobed response word
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && strobe === 1'b1) begin
         if (min_report_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word: min %0d empty %0b ovf %0b",
                                      rsp_word.min_value, rsp_word.is_empty,
                                      rsp_word.overflow));
         end else begin
            want = min_report_q.pop_front();
            rsp_count++;
            if (rsp_word.min_value !== want.min_value)
               report_mismatch($sformatf("word %0d min_value %0d, want %0d", rsp_count,
                                         rsp_word.min_value, want.min_value));
            if (rsp_word.is_empty !== want.is_empty)
               report_mismatch($sformatf("word %0d is_empty %b, want %b", rsp_count,
                                         rsp_word.is_empty, want.is_empty));
            if (rsp_word.overflow !== want.overflow)
               report_mismatch($sformatf("word %0d overflow %b, want %b", rsp_count,
                                         rsp_word.overflow, want.overflow));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, min_report_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: build all stimulus, release reset, wait for the end
   // ------------------------------------------------------------------------
   initial begin
      burst_mode_type mode;
      int             total;
      int             len;
      bit             steady;

      // directed opening: empty queue, extremes, duplicates, last pop
      queue_req(OP_PEEK,    32'h1234_5678, pick_gap(1'b0), 1'b0);
      queue_req(OP_POP,     32'hFFFF_FFFF, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'h0000_0000, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'h7FFF_FFFF, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'h8000_0000, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'hFFFF_FFFF, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'h8000_0000, pick_gap(1'b0), 1'b0);
      queue_req(OP_PEEK,    32'h0000_0000, pick_gap(1'b0), 1'b0);
      repeat (5)
         queue_req(OP_POP, 32'h0000_0000, pick_gap(1'b0), 1'b0);
      queue_req(OP_POP,     32'h7FFF_FFFF, pick_gap(1'b0), 1'b0);
      queue_req(OP_PRELOAD, 32'sd5,        pick_gap(1'b0), 1'b0);
      queue_req(OP_PRELOAD, -32'sd5,       pick_gap(1'b0), 1'b0);
      queue_req(OP_PRELOAD, 32'sd5,        pick_gap(1'b0), 1'b0);
      queue_req(OP_PEEK,    32'h0000_0000, 0,              1'b1);
      queue_req(OP_INSERT,  32'h5555_5555, pick_gap(1'b0), 1'b0);
      queue_req(OP_INSERT,  32'hAAAA_AAAA, pick_gap(1'b0), 1'b0);
      repeat (4)
         queue_req(OP_POP, 32'h0000_0000, pick_gap(1'b0), 1'b0);

      // fill past capacity so inserts and preloads get dropped, then drain
      queue_req(OP_PRELOAD, pick_value(), 0, 1'b1);
      repeat (CAPACITY + 10)
         queue_req(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_PRELOAD,
                   pick_value(), pick_gap(1'b0), 1'b0);
      repeat (CAPACITY + 12)
         queue_req(($urandom_range(0, 5) != 0) ? OP_POP : OP_PEEK,
                   pick_value(), pick_gap(1'b0), 1'b0);

      // random bursts of varying mix
      total = 2 * CAPACITY + 47;
      while (total < RAND_ITEMS) begin
         mode   = burst_mode_type'($urandom_range(0, 2));
         len    = $urandom_range(10, 60);
         steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++)
            queue_req(pick_func(mode), pick_value(), pick_gap(steady),
                      (i == 0) && ($urandom_range(0, 2) == 0));
         total += len;
      end

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || min_report_q.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Ran %0d request words, checked %0d responses in %0d cycles",
               req_count, rsp_count, cycle_count);
      $display("Peak depth %0d of %0d, %0d dropped inserts, %0d empty reports",
               max_depth, CAPACITY, drop_count, empty_count);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", err_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mpq_pkg.sv
hdl/mpq_cell.sv
hdl/min_priority_queue_core.sv
tb/min_priority_queue_core_tb.sv
